[rtl/core/ppmfd_pkg.sv]
// Package for the PPM frame decoder: constants, state and operation codes.
// Used by ppmfd_divider and ppm_frame_decoder_top.
package ppmfd_pkg;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam logic [15:0] SHORT_LIMIT_RST = 16'd800;
    localparam logic [15:0] FRAME_GAP_RST = 16'd6000;
    localparam logic [15:0] CAL_RESET_MIN = 16'd9999;
    localparam logic [15:0] CAL_RESET_MAX = 16'd0;
    localparam logic [15:0] MIN_BOUND_RST = 16'd1000;
    localparam logic [15:0] MAX_BOUND_RST = 16'd2000;
    localparam logic [31:0] LOST_VALUE = 32'hFFFF_FFFF;
    localparam int QUO_W = 34;

    typedef enum logic [1:0] {
        OP_EDGE = 2'd0,
        OP_CALIBRATE = 2'd1,
        OP_CAL_RESET = 2'd2,
        OP_LOAD = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_SHORT_LIMIT = 3'd0,
        REG_FRAME_GAP = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_THROTTLE = 3'd3,
        REG_OUTPUT_LOW = 3'd4,
        REG_OUTPUT_HIGH = 3'd5,
        REG_DEF_MIN = 3'd6,
        REG_DEF_MAX = 3'd7
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_EMIT_RD,
        ST_EMIT_MUL,
        ST_EMIT_DIV,
        ST_EMIT_OUT
    } t_state;
endpackage

[rtl/core/ppmfd_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle, sign applied at the end.
// Depends on ppmfd_pkg.
module ppmfd_divider import ppmfd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [QUO_W-1:0] i_dividend,
    input  logic [15:0]             i_divisor,
    output logic                    o_done,
    output logic signed [QUO_W-1:0] o_quotient
);
    logic [QUO_W-1:0] r_num;
    logic [QUO_W-1:0] r_quo;
    logic [16:0]      r_rem;
    logic [15:0]      r_den;
    logic             r_neg;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [16:0]      rem_shift;
    logic [16:0]      rem_sub;

    assign rem_shift = {r_rem[15:0], r_num[QUO_W-1]};
    assign rem_sub = rem_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'(QUO_W);
                r_neg <= i_dividend[QUO_W-1];
                r_num <= i_dividend[QUO_W-1] ? QUO_W'(-i_dividend) : i_dividend;
                r_den <= i_divisor;
                r_rem <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[QUO_W-2:0], 1'b0};
                if (!rem_sub[16]) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_shift;
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_neg ? QUO_W'(-r_quo) : r_quo;
endmodule

[rtl/core/ppm_frame_decoder_top.sv]
// PPM frame decoder top: edge timing, channel store, calibration and mapping.
// An edge that does not end a frame is taken with the decoder staying idle. A frame-completing
// edge walks the channels in turn through read, multiply, the serial divider and output,
// holding while the output stalls; input waits until the last channel. Bound ops read and
// write back each channel in turn: count channels for calibrate and reset, MAX_CHANNELS for
// load. Reset (synchronous, active low) restores registers and sets the bound memory to the
// reset bounds in a pass over all MAX_CHANNELS entries before the first item is accepted.
module ppm_frame_decoder_top import ppmfd_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] operation, [33:2] timestamp_us
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [2:0] channel_number, [18:3] pulse_width_us,
                                        // [50:19] mapped_value
    output logic        m_axis_tuser,   // signal_lost
    output logic        m_axis_tlast,   // last_channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = $clog2(MAX_CHANNELS + 1);

    // configuration
    logic [15:0] r_short, r_gap, r_def_min, r_def_max;
    logic signed [15:0] r_out_lo, r_out_hi;
    logic [3:0]  r_count, r_thr;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= SHORT_LIMIT_RST; r_gap <= FRAME_GAP_RST;
            r_count <= 4'd8; r_thr <= 4'd0;
            r_out_lo <= 16'sd0; r_out_hi <= 16'sd1000;
            r_def_min <= MIN_BOUND_RST; r_def_max <= MAX_BOUND_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_SHORT_LIMIT:   r_short <= i_cfg_data;
                REG_FRAME_GAP:     r_gap <= i_cfg_data;
                REG_CHANNEL_COUNT: r_count <= i_cfg_data[3:0];
                REG_THROTTLE:      r_thr <= i_cfg_data[3:0];
                REG_OUTPUT_LOW:    r_out_lo <= i_cfg_data;
                REG_OUTPUT_HIGH:   r_out_hi <= i_cfg_data;
                REG_DEF_MIN:       r_def_min <= i_cfg_data;
                REG_DEF_MAX:       r_def_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [CW-1:0] eff_n;
    always_comb begin
        if (r_count == 4'd0) eff_n = CW'(1);
        else if (32'(r_count) > MAX_CHANNELS) eff_n = CW'(MAX_CHANNELS);
        else eff_n = CW'(r_count);
    end

    // memories: frame widths, latched widths, bounds {max,min}
    logic [15:0] frame_mem [MAX_CHANNELS];
    logic [15:0] latch_mem [MAX_CHANNELS];
    logic [31:0] bound_mem [MAX_CHANNELS];

    // frame widths live in flops copied into latched on frame end (a row copy)
    logic [31:0] r_last;
    logic [CW-1:0] r_ptr;

    t_state r_state, n_state;
    logic [CW-1:0] r_idx;
    logic [1:0]  r_op;
    logic        r_clear;
    logic [15:0] r_rd_w;
    logic [31:0] r_rd_b;
    logic [IW-1:0] rd_addr;
    logic        bnd_we;
    logic [31:0] bnd_wd;
    logic        r_degen, r_lost;
    logic        div_start, div_done;
    logic signed [33:0] div_q;
    logic        r_ovalid;
    logic [55:0] r_odata;
    logic        r_olast, r_olost;

    assign rd_addr = r_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        r_rd_w <= latch_mem[rd_addr];
        r_rd_b <= bound_mem[rd_addr];
        if (bnd_we) bound_mem[rd_addr] <= bnd_wd;
    end

    logic [1:0]  in_op;
    logic [31:0] in_ts, elapsed;
    logic        in_acc, frame_done;
    assign in_op = s_axis_tdata[1:0];
    assign in_ts = s_axis_tdata[33:2];
    assign elapsed = in_ts - r_last;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_clear;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    logic [CW-1:0] wptr;
    assign wptr = (r_ptr >= eff_n) ? '0 : r_ptr;
    assign frame_done = in_acc && (t_op'(in_op) == OP_EDGE)
                      && !(elapsed < 32'(r_short)) && !(elapsed > 32'(r_gap))
                      && (wptr + CW'(1) >= eff_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_ptr <= '0;
        end else if (in_acc && t_op'(in_op) == OP_EDGE && !(elapsed < 32'(r_short))) begin
            r_last <= in_ts;
            if (elapsed > 32'(r_gap)) r_ptr <= '0;
            else if (wptr + CW'(1) >= eff_n) r_ptr <= '0;
            else r_ptr <= wptr + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                frame_mem[k] <= '0;
                latch_mem[k] <= '0;
            end
        end else if (in_acc && t_op'(in_op) == OP_EDGE && !(elapsed < 32'(r_short))
                     && !(elapsed > 32'(r_gap))) begin
            frame_mem[wptr[IW-1:0]] <= (elapsed > 32'd65535) ? 16'hFFFF : elapsed[15:0];
            if (frame_done) begin
                for (int k = 0; k < MAX_CHANNELS; k++)
                    latch_mem[k] <= (k == int'(wptr))
                        ? ((elapsed > 32'd65535) ? 16'hFFFF : elapsed[15:0])
                        : frame_mem[k];
            end
        end
    end

    // bound sweep limit: calibrate/reset over count, load and clear over all
    logic [CW-1:0] sweep_n;
    assign sweep_n = (r_clear || t_op'(r_op) == OP_LOAD) ? CW'(MAX_CHANNELS) : eff_n;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (r_clear) n_state = ST_IDLE;
                else if (in_acc && t_op'(in_op) != OP_EDGE) n_state = ST_BOUNDS;
                else if (frame_done) n_state = ST_EMIT_RD;
            end
            ST_BOUNDS:   if (r_idx + CW'(1) >= sweep_n) n_state = ST_IDLE;
            ST_EMIT_RD:  n_state = ST_EMIT_MUL;
            ST_EMIT_MUL: n_state = ST_EMIT_DIV;
            ST_EMIT_DIV: if (div_done) n_state = ST_EMIT_OUT;
            ST_EMIT_OUT: if (!r_ovalid) n_state = (r_idx + CW'(1) >= eff_n) ? ST_IDLE : ST_EMIT_RD;
            default: n_state = ST_IDLE;
        endcase
    end

    // ST_BOUNDS runs two phases per entry via r_phase: read, then write back
    logic r_phase;
    logic [15:0] cur_min, cur_max;
    assign cur_min = r_rd_b[15:0];
    assign cur_max = r_rd_b[31:16];

    always_comb begin
        bnd_we = 1'b0;
        bnd_wd = r_rd_b;
        if (r_clear) begin
            bnd_we = 1'b1;
            bnd_wd = {MAX_BOUND_RST, MIN_BOUND_RST};
        end else if (r_state == ST_BOUNDS && r_phase) begin
            bnd_we = 1'b1;
            case (t_op'(r_op))
                OP_CALIBRATE: bnd_wd = {(r_rd_w > cur_max) ? r_rd_w : cur_max,
                                        (r_rd_w < cur_min) ? r_rd_w : cur_min};
                OP_CAL_RESET: bnd_wd = {CAL_RESET_MAX, CAL_RESET_MIN};
                default:      bnd_wd = {r_def_max, r_def_min};
            endcase
        end
    end

    assign div_start = (r_state == ST_EMIT_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_clear <= 1'b1;
            r_idx <= '0;
            r_phase <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_clear) begin
                if (r_idx + CW'(1) >= CW'(MAX_CHANNELS)) begin
                    r_clear <= 1'b0;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_phase <= 1'b0;
                    if (!r_clear) r_idx <= '0;
                    if (in_acc) r_op <= in_op;
                end
                ST_BOUNDS: begin
                    // phase 0 reads, phase 1 writes back
                    r_phase <= !r_phase;
                    if (r_phase) r_idx <= (n_state == ST_IDLE) ? '0 : r_idx + CW'(1);
                end
                ST_EMIT_MUL: begin
                    r_degen <= !(cur_max > cur_min);
                    r_lost <= (r_thr != 4'd0) && (32'(r_thr) == 32'(r_idx) + 1)
                              && (r_rd_w < cur_min);
                end
                ST_EMIT_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_olast <= (r_idx + CW'(1) >= eff_n);
                        r_olost <= r_lost;
                        r_odata <= {5'd0,
                            r_lost ? LOST_VALUE :
                            (r_degen ? 32'($signed(r_out_lo))
                                     : 32'(div_q) + 32'($signed(r_out_lo))),
                            r_rd_w, 3'(r_idx)};
                        r_idx <= r_idx + CW'(1);
                    end
                end
                default: ;
            endcase
            if (!(r_state == ST_BOUNDS && !r_phase)) r_state <= n_state;
        end
    end

    // divider operands formed from the registered read
    logic signed [33:0] prod_in;
    logic [15:0]        span_in;
    assign prod_in = 34'(($signed({1'b0, r_rd_w}) - $signed({1'b0, cur_min}))
                     * ($signed({r_out_hi[15], r_out_hi})
                        - $signed({r_out_lo[15], r_out_lo})));
    assign span_in = (cur_max > cur_min) ? (cur_max - cur_min) : 16'd1;

    ppmfd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_in),
        .i_divisor  (span_in),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_olost;
    assign m_axis_tlast = r_olast;
endmodule

[bench/ppm_frame_decoder_top_tb.sv]
// Testbench for ppm_frame_decoder_top: drives edge and calibration transactions,
// predicts channel results in a scoreboard class. Depends on ppmfd_pkg and the RTL.
`timescale 1ns / 100ps

module ppm_frame_decoder_top_tb;
    import ppmfd_pkg::*;

    localparam int NCH = MAX_CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  chan;
        logic [15:0] width;
        logic [31:0] mapped;
        logic        lost;
        logic        last;
    } t_chan_res;

    class ppm_scoreboard;
        logic [15:0] short_limit, frame_gap, out_lo, out_hi, def_min, def_max;
        logic [3:0]  chan_count, throttle;
        logic [31:0] last_edge;
        int unsigned frame_pos;
        logic [15:0] frame_w[NCH], latched_w[NCH], min_b[NCH], max_b[NCH];
        t_chan_res   pending[$];
        int          errors;

        function new();
            short_limit = SHORT_LIMIT_RST; frame_gap = FRAME_GAP_RST;
            chan_count = 4'd8; throttle = 4'd0; out_lo = 16'd0; out_hi = 16'd1000;
            def_min = 16'd1000; def_max = 16'd2000; last_edge = 0; frame_pos = 0;
            errors = 0;
            for (int i = 0; i < NCH; i++) begin
                frame_w[i] = 0; latched_w[i] = 0;
                min_b[i] = MIN_BOUND_RST; max_b[i] = MAX_BOUND_RST;
            end
        endfunction

        function void write_reg(t_reg idx, logic [15:0] v);
            case (idx)
                REG_SHORT_LIMIT:   short_limit = v;
                REG_FRAME_GAP:     frame_gap = v;
                REG_CHANNEL_COUNT: chan_count = v[3:0];
                REG_THROTTLE:      throttle = v[3:0];
                REG_OUTPUT_LOW:    out_lo = v;
                REG_OUTPUT_HIGH:   out_hi = v;
                REG_DEF_MIN:       def_min = v;
                REG_DEF_MAX:       def_max = v;
            endcase
        endfunction

        function int unsigned active_count();
            if (chan_count == 0) return 1;
            if (chan_count > NCH) return NCH;
            return chan_count;
        endfunction

        function logic [31:0] map_width(int i);
            longint w, lo, hi, q;
            w = latched_w[i]; lo = min_b[i]; hi = max_b[i];
            if (hi <= lo) return 32'(longint'($signed(out_lo)));
            q = (w - lo) * (longint'($signed(out_hi)) - longint'($signed(out_lo))) / (hi - lo);
            return 32'(q + longint'($signed(out_lo)));
        endfunction

        function void note_item(t_op op, logic [31:0] ts);
            int unsigned n;
            logic [31:0] elapsed;
            t_chan_res r;
            n = active_count();
            case (op)
                OP_CALIBRATE:
                    for (int i = 0; i < n; i++) begin
                        if (latched_w[i] < min_b[i]) min_b[i] = latched_w[i];
                        if (latched_w[i] > max_b[i]) max_b[i] = latched_w[i];
                    end
                OP_CAL_RESET:
                    for (int i = 0; i < n; i++) begin
                        min_b[i] = CAL_RESET_MIN; max_b[i] = CAL_RESET_MAX;
                    end
                OP_LOAD:
                    for (int i = 0; i < NCH; i++) begin
                        min_b[i] = def_min; max_b[i] = def_max;
                    end
                default: begin
                    elapsed = ts - last_edge;
                    if (elapsed < short_limit) return;
                    last_edge = ts;
                    if (elapsed > frame_gap) begin
                        frame_pos = 0;
                        return;
                    end
                    if (frame_pos >= n) frame_pos = 0;
                    frame_w[frame_pos] = (elapsed > 32'hFFFF) ? 16'hFFFF : elapsed[15:0];
                    frame_pos++;
                    if (frame_pos < n) return;
                    frame_pos = 0;
                    latched_w = frame_w;
                    for (int i = 0; i < n; i++) begin
                        r.chan = 3'(i);
                        r.width = latched_w[i];
                        r.lost = (throttle != 0) && (i == throttle - 1) &&
                                 (latched_w[i] < min_b[i]);
                        r.mapped = r.lost ? LOST_VALUE : map_width(i);
                        r.last = (i + 1 == n);
                        pending.push_back(r);
                    end
                end
            endcase
        endfunction

        function void check_result(t_chan_res got);
            t_chan_res exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.chan !== exp_r.chan) begin
                $display("%0t: channel_number exp %0d got %0d", $time, exp_r.chan, got.chan);
                errors++;
            end
            if (got.width !== exp_r.width) begin
                $display("%0t: pulse_width_us exp %0d got %0d", $time, exp_r.width, got.width);
                errors++;
            end
            if (got.mapped !== exp_r.mapped) begin
                $display("%0t: mapped_value exp %0d got %0d", $time,
                         $signed(exp_r.mapped), $signed(got.mapped));
                errors++;
            end
            if (got.lost !== exp_r.lost) begin
                $display("%0t: signal_lost exp %0b got %0b", $time, exp_r.lost, got.lost);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $display("%0t: last_channel exp %0b got %0b", $time, exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    ppm_scoreboard decode_sb = new();
    int unsigned cycles = 0;
    logic [31:0] edge_clock = 0;
    int unsigned burst_left = 0;

    always #1 i_clk = ~i_clk;

    ppm_frame_decoder_top DUT (.*);

    // Receiver stall pattern: long open stretches mixed with choppy ones.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles[9]) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            decode_sb.check_result({m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tdata[50:19],
                                    m_axis_tuser, m_axis_tlast});
    end

    task automatic write_cfg(t_reg idx, logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        decode_sb.write_reg(idx, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(t_op op, logic [31:0] ts);
        int unsigned gap;
        // Insert gaps between bursts of random length.
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, ts, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_sb.note_item(op, ts);
    endtask

    task automatic send_edge(logic [31:0] delta);
        edge_clock = edge_clock + delta;
        send_item(OP_EDGE, edge_clock);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (decode_sb.pending.size() != 0) @(posedge i_clk);
        // Calibration walks may still be running with no result to wait for.
        repeat (400) @(posedge i_clk);
    endtask

    // One frame: sync gap then channel widths, some short glitches and some long widths.
    task automatic send_frame(int unsigned n);
        send_edge(decode_sb.frame_gap + 1 + $urandom_range(0, 3000));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) send_edge($urandom_range(0, 50));
            if ($urandom_range(0, 7) == 0) send_edge($urandom_range(0, 65535) & 16'hFFFF);
            else send_edge($urandom_range(700, 2300));
        end
    endtask

    initial begin
        t_op rop;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default frame, calibration ops, extreme timestamps.
        send_frame(8);
        send_item(OP_CALIBRATE, 32'hFFFF_FFFF);
        send_item(OP_CAL_RESET, 32'h0);
        send_frame(8);
        send_item(OP_LOAD, 32'hAAAA_5555);
        send_item(OP_EDGE, 32'hFFFF_FFFF);
        send_item(OP_EDGE, 32'h0000_0000);
        edge_clock = 0;
        drain();

        write_cfg(REG_SHORT_LIMIT, 16'd0);
        write_cfg(REG_FRAME_GAP, 16'hFFFF);
        write_cfg(REG_CHANNEL_COUNT, 16'd3);
        write_cfg(REG_THROTTLE, 16'd2);
        write_cfg(REG_OUTPUT_LOW, 16'h8000);
        write_cfg(REG_OUTPUT_HIGH, 16'h7FFF);
        write_cfg(REG_DEF_MIN, 16'd1500);
        write_cfg(REG_DEF_MAX, 16'd1500);
        send_item(OP_LOAD, 32'h0);
        send_edge(32'd70000);
        send_edge(32'd0);
        send_edge(32'd1000);
        send_edge(32'd2000);
        send_edge(32'd65535);
        send_edge(32'd1600);
        drain();

        // Random phases over several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(REG_SHORT_LIMIT, ph == 5 ? 16'hFFFF : 16'($urandom_range(0, 800)));
            write_cfg(REG_FRAME_GAP, ph == 0 ? 16'd0 : 16'($urandom_range(2500, 65535)));
            write_cfg(REG_CHANNEL_COUNT, ph == 1 ? 16'd0 : ph == 2 ? 16'd15 :
                      16'($urandom_range(1, 8)));
            write_cfg(REG_THROTTLE, 16'($urandom_range(0, 15)));
            write_cfg(REG_OUTPUT_LOW, 16'($urandom));
            write_cfg(REG_OUTPUT_HIGH, 16'($urandom));
            write_cfg(REG_DEF_MIN, 16'($urandom_range(0, 2000)));
            write_cfg(REG_DEF_MAX, 16'($urandom_range(0, 65535)));
            for (int k = 0; k < 14; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    rop = t_op'($urandom_range(0, 3));
                    send_item(rop, $urandom);
                end else begin
                    send_frame(decode_sb.active_count());
                end
                if (k == 6 && ph == 3) begin
                    // Lower the count mid-frame so the pointer lands past it.
                    send_edge(32'd1200);
                    send_edge(32'd1200);
                    drain();
                    write_cfg(REG_CHANNEL_COUNT, 16'd1);
                    send_edge(32'd1300);
                end
            end
            drain();
        end

        if (decode_sb.errors == 0 && decode_sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/ppmfd_pkg.sv
rtl/core/ppmfd_divider.sv
rtl/core/ppm_frame_decoder_top.sv
bench/ppm_frame_decoder_top_tb.sv
